// File: src/assert_macros.svh
// Assertion helpers used by the assertion checker in gww_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_RUN(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: src/gww_pkg.sv
package gww_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLACE,
      ST_CHARS,
      ST_SPACE,
      ST_FINAL
   } state_type;

   typedef enum logic [1:0] {
      EMIT_CHAR,
      EMIT_SPACE,
      EMIT_NEWLINE
   } emit_sel_type;

   typedef struct packed {
      logic accept;
      logic pos_incr;
      logic emit;
      emit_sel_type emit_sel;
      logic emit_last;
      logic fill_clear;
      logic fill_add;
      logic count_clear;
   } cmd_type;

   typedef struct packed {
      logic is_sep;
      logic count_zero;
      logic overflow;
      logic fill_zero;
      logic pos_last;
      logic eot;
      logic slot_free;
   } status_type;

endpackage

// File: src/gww_datapath.sv
module gww_datapath #(
   parameter int MAX_WORD = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic [7:0] req_tdata,
   input  logic req_tlast,
   input  gww_pkg::cmd_type cmd,
   output gww_pkg::status_type status,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic rsp_tlast
);
   import gww_pkg::*;

   localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int CW = $clog2(MAX_WORD + 1);

   logic [7:0] word_mem [MAX_WORD];
   logic [7:0] mem_q_ff;

   logic [7:0] line_width_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0] fill_ff, fill_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic eot_ff, eot_in;
   logic out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic out_last_ff, out_last_in;

   logic is_sep, room, wr_en;
   logic [8:0] need;

   assign is_sep = (req_tdata == CHAR_SPACE) || (req_tdata == CHAR_NEWLINE);
   assign room = count_ff < CW'(MAX_WORD);
   assign wr_en = cmd.accept && !is_sep && room;
   // Line length after this word and its trailing space.
   assign need = {1'b0, fill_ff} + 9'(count_ff) + 9'd1;

   always_comb begin
      status.is_sep = is_sep;
      status.count_zero = (count_ff == '0);
      status.overflow = (need >= {1'b0, line_width_ff});
      status.fill_zero = (fill_ff == '0);
      status.pos_last = ((CW'(pos_ff) + CW'(1)) == count_ff);
      status.eot = eot_ff;
      status.slot_free = !out_valid_ff || rsp_tready;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.fill_clear) begin
         fill_in = '0;
      end else if (cmd.fill_add) begin
         fill_in = need[7:0];
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.accept) begin
         pos_in = '0;
      end else if (cmd.pos_incr) begin
         pos_in = pos_ff + AW'(1);
      end
   end

   assign eot_in = cmd.accept ? req_tlast : eot_ff;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in = out_char_ff;
      out_last_in = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_last_in = cmd.emit_last;
         unique case (cmd.emit_sel)
            EMIT_CHAR: out_char_in = mem_q_ff;
            EMIT_SPACE: out_char_in = CHAR_SPACE;
            EMIT_NEWLINE: out_char_in = CHAR_NEWLINE;
            default: out_char_in = CHAR_NEWLINE;
         endcase
      end
   end

   // The read address follows the next position, so the registered read
   // data always holds the entry at the current position.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_mem[count_ff[AW-1:0]] <= req_tdata;
      end
      mem_q_ff <= word_mem[pos_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         count_ff <= '0;
         fill_ff <= '0;
         pos_ff <= '0;
         eot_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            line_width_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         fill_ff <= fill_in;
         pos_ff <= pos_in;
         eot_ff <= eot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_char_ff;
   assign rsp_tlast = out_last_ff;

endmodule

// File: src/gww_ctrl.sv
module gww_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tlast,
   output logic req_tready,
   input  gww_pkg::status_type status,
   output gww_pkg::cmd_type cmd
);
   import gww_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (status.is_sep) begin
                  if (!status.count_zero) begin
                     state_in = ST_PLACE;
                  end else if (req_tlast) begin
                     state_in = ST_FINAL;
                  end
               end else if (req_tlast) begin
                  state_in = ST_PLACE;
               end
            end
         end
         ST_PLACE: begin
            if (!(status.overflow && !status.fill_zero) || status.slot_free) begin
               state_in = ST_CHARS;
            end
         end
         ST_CHARS: begin
            if (status.slot_free && status.pos_last) begin
               state_in = ST_SPACE;
            end
         end
         ST_SPACE: begin
            if (status.slot_free) begin
               state_in = status.eot ? ST_FINAL : ST_IDLE;
            end
         end
         ST_FINAL: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.emit_sel = EMIT_CHAR;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_PLACE: begin
            // A word that does not fit starts a fresh line; the newline is
            // needed only when the current line already holds something.
            if (status.overflow) begin
               if (status.fill_zero) begin
                  cmd.fill_clear = 1'b1;
               end else if (status.slot_free) begin
                  cmd.fill_clear = 1'b1;
                  cmd.emit = 1'b1;
                  cmd.emit_sel = EMIT_NEWLINE;
               end
            end
         end
         ST_CHARS: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.pos_incr = 1'b1;
            end
         end
         ST_SPACE: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.emit_sel = EMIT_SPACE;
               cmd.fill_add = 1'b1;
               cmd.count_clear = 1'b1;
            end
         end
         ST_FINAL: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.emit_sel = EMIT_NEWLINE;
               cmd.emit_last = 1'b1;
               cmd.fill_clear = 1'b1;
               cmd.count_clear = 1'b1;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/greedy_word_wrap_unit.sv
// Greedy word wrap. Text bytes enter on the req_ channel, one byte per
// request, with req_tlast on the final byte of a text. Wrapped text leaves
// on the rsp_ channel, one byte per transfer, with rsp_tlast on the newline
// that closes the text. The line width is written through csr_wr_en and
// csr_wr_data; the user must write it only while the block is idle, as the
// block does not enforce this. Reset sets it to 80. A byte that extends
// the current word is taken and makes no output. A separator or final
// byte that closes a word is taken, the fit is checked (and a newline sent
// if needed), the word is streamed out of its buffer memory, and the
// trailing space follows; the final newline comes last. The single read
// port of the word memory sets the pace of one output byte per cycle
// while the receiver is ready. A leading newline leaves from the fit
// check, else the first word byte from the state after it.
// Reset empties the word buffer and the line, and drops any pending output.
// When the receiver stalls, the output register holds its byte and the
// controller waits; new requests are taken only once a word is fully sent.
module greedy_word_wrap_unit #(
   parameter int MAX_WORD = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic rsp_tlast
);
   import gww_pkg::*;

   cmd_type cmd;
   status_type status;

   gww_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tlast(req_tlast),
      .req_tready(req_tready),
      .status(status),
      .cmd(cmd)
   );

   gww_datapath #(
      .MAX_WORD(MAX_WORD)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .cmd(cmd),
      .status(status),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

endmodule

// File: src/gww_checker.sv
`include "assert_macros.svh"

module gww_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic req_tlast,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic rsp_tlast
);
   import gww_pkg::*;

   `ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_tvalid)
   `ASSERT_RUN(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `ASSERT_RUN(a_last_is_newline, clock, reset,
      rsp_tvalid && rsp_tlast |-> rsp_tdata == CHAR_NEWLINE)
   `ASSERT_RUN(a_busy_after_end, clock, reset,
      req_tvalid && req_tready && req_tlast |=> !req_tready)

endmodule

bind greedy_word_wrap_unit gww_checker u_gww_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tlast(req_tlast),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);

// File: sim/greedy_word_wrap_unit_checker.sv
`timescale 1ns / 1ps

// Watches the request, response and CSR channels, keeps its own copy of the
// wrap state and compares every response byte with the oldest predicted one.
module greedy_word_wrap_unit_checker #(
   parameter int MAX_WORD = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [7:0] req_tdata,
   input  logic req_tlast,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic rsp_tlast,
   output int fail_count,
   output int pending_count
);

   import gww_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic fin;
   } text_byte_type;

   text_byte_type expected_text[$];
   logic [7:0] width_q;
   logic [7:0] word_buf [MAX_WORD];
   int word_len;
   int line_fill;
   int n_fail;

   function automatic void push_byte(logic [7:0] ch, logic fin);
      text_byte_type tb;
      tb.ch = ch;
      tb.fin = fin;
      expected_text.push_back(tb);
   endfunction

   // Puts the pending word on the current line, or on a fresh one when the
   // line plus word plus trailing space would reach the width.
   function automatic void place_word();
      if (word_len == 0)
         return;
      if (line_fill + word_len + 1 >= int'(width_q)) begin
         if (line_fill > 0)
            push_byte(CHAR_NEWLINE, 1'b0);
         line_fill = 0;
      end
      for (int i = 0; i < word_len; i++)
         push_byte(word_buf[i], 1'b0);
      push_byte(CHAR_SPACE, 1'b0);
      line_fill += word_len + 1;
      word_len = 0;
   endfunction

   function automatic void predict_wrap(logic [7:0] ch, logic fin);
      if (ch == CHAR_SPACE || ch == CHAR_NEWLINE) begin
         place_word();
      end else if (word_len < MAX_WORD) begin
         word_buf[word_len] = ch;
         word_len++;
      end
      if (fin) begin
         place_word();
         push_byte(CHAR_NEWLINE, 1'b1);
         line_fill = 0;
         word_len = 0;
      end
   endfunction

   always @(posedge clock) begin
      text_byte_type want;
      if (reset) begin
         width_q = LINE_WIDTH_RESET;
         word_len = 0;
         line_fill = 0;
         expected_text.delete();
      end else begin
         if (csr_wr_en)
            width_q = csr_wr_data;
         if (req_tvalid && req_tready)
            predict_wrap(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("%0t: unexpected response %h last %b", $time, rsp_tdata,
                           rsp_tlast);
            end else begin
               want = expected_text.pop_front();
               if (rsp_tdata !== want.ch || rsp_tlast !== want.fin) begin
                  n_fail++;
                  if (n_fail <= 10)
                     $display("%0t: mismatch: expected %h last %b, got %h last %b",
                              $time, want.ch, want.fin, rsp_tdata, rsp_tlast);
               end
            end
         end
      end
      fail_count <= n_fail;
      pending_count <= expected_text.size();
   end

endmodule

// File: sim/greedy_word_wrap_unit_tb.sv
`timescale 1ns / 1ps

module greedy_word_wrap_unit_tb;

   import gww_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int ITEMS_PER_PHASE = 32;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;
   logic req_tvalid = 1'b0;
   logic [7:0] req_tdata = 8'd0;
   logic req_tlast = 1'b0;
   logic rsp_tready = 1'b0;
   logic req_tready;
   logic rsp_tvalid;
   logic [7:0] rsp_tdata;
   logic rsp_tlast;

   int fail_count;
   int pending_count;
   int burst_left = 0;
   int sent_total = 0;
   int idle_cycles = 0;
   logic want_hold = 1'b0;

   always #5 clock = ~clock;

   greedy_word_wrap_unit i_dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   greedy_word_wrap_unit_checker i_checker (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** greedy_word_wrap_unit: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: picks a new stall pattern at random intervals and, once
   // asked, holds off for a long stretch so the block backs up.
   initial begin
      int mode;
      int mode_left;
      logic hold_done;
      mode = 0;
      mode_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (want_hold && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   task automatic send_request(input logic [7:0] ch, input logic fin);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tlast <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      sent_total++;
   endtask

   task automatic write_width(input logic [7:0] w);
      csr_wr_en <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits for every predicted byte and then pauses, so the block is
   // idle before the width changes.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Mostly printable text; one byte in ten is any value at all.
   function automatic logic [7:0] pick_text_char();
      if ($urandom_range(0, 9) == 0)
         return 8'($urandom_range(0, 255));
      return 8'($urandom_range(33, 126));
   endfunction

   task automatic run_phase(input logic [7:0] width, input int items);
      logic [7:0] text_q[$];
      int start_count;
      int n_words;
      int len;
      int n_sep;
      int r;
      write_width(width);
      start_count = sent_total;
      while (sent_total - start_count < items) begin
         text_q.delete();
         n_words = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
         for (int w = 0; w < n_words; w++) begin
            r = $urandom_range(0, 99);
            len = (r < 6) ? $urandom_range(30, 40) : (r < 10) ? 0 : $urandom_range(1, 9);
            for (int i = 0; i < len; i++)
               text_q.push_back(pick_text_char());
            n_sep = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
            repeat (n_sep)
               text_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_NEWLINE);
         end
         // An empty text becomes a lone separator; any other text ends on a
         // separator or gets one more byte that still belongs to the final word.
         if (text_q.size() == 0)
            text_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_NEWLINE);
         else if ($urandom_range(0, 1))
            text_q.push_back(pick_text_char());
         // The last text of a phase is cut short so the phase sends exactly
         // its share of requests.
         while (text_q.size() > items - (sent_total - start_count))
            void'(text_q.pop_back());
         foreach (text_q[i])
            send_request(text_q[i], i == text_q.size() - 1);
      end
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset width: extreme bytes, repeated separators, end bytes that make
      // a word of their own, and texts made of a lone separator.
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(CHAR_SPACE, 1'b0);
      send_request(CHAR_SPACE, 1'b0);
      send_request(CHAR_NEWLINE, 1'b0);
      send_request(8'h61, 1'b1);
      send_request(CHAR_SPACE, 1'b1);
      send_request(CHAR_NEWLINE, 1'b1);
      send_request(8'h7F, 1'b0);
      send_request(8'h80, 1'b0);
      send_request(CHAR_NEWLINE, 1'b0);
      send_request(8'hFE, 1'b1);
      drain();

      // A width of 3, then zero, where every word is oversized.
      write_width(8'd3);
      send_request(8'h61, 1'b0);
      send_request(8'h62, 1'b0);
      send_request(CHAR_SPACE, 1'b0);
      send_request(8'h63, 1'b1);
      drain();
      write_width(8'd0);
      send_request(8'h7A, 1'b0);
      send_request(CHAR_SPACE, 1'b0);
      send_request(8'h79, 1'b1);
      drain();

      run_phase(8'd255, ITEMS_PER_PHASE);
      run_phase(8'd1, ITEMS_PER_PHASE);
      run_phase(8'd2, ITEMS_PER_PHASE);
      want_hold <= 1'b1;
      run_phase(8'd12, ITEMS_PER_PHASE);
      run_phase(8'd3, ITEMS_PER_PHASE);
      run_phase(8'($urandom_range(3, 40)), ITEMS_PER_PHASE);
      run_phase(8'($urandom_range(3, 40)), ITEMS_PER_PHASE);
      run_phase(8'($urandom_range(3, 255)), ITEMS_PER_PHASE);
      run_phase(LINE_WIDTH_RESET, ITEMS_PER_PHASE);

      repeat (16) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("** greedy_word_wrap_unit: PASSED **");
      else
         $display("** greedy_word_wrap_unit: FAILED **");
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/gww_pkg.sv
src/gww_datapath.sv
src/gww_ctrl.sv
src/greedy_word_wrap_unit.sv
src/gww_checker.sv
sim/greedy_word_wrap_unit_checker.sv
sim/greedy_word_wrap_unit_tb.sv
